>>> hdl/motion_template_matcher_unit_assert.svh
// Assertion macros shared by the motion template matcher RTL.
// Expects clk and rst_n in scope at every use; no other dependencies.
`ifndef MOTION_TEMPLATE_MATCHER_UNIT_ASSERT_SVH
`define MOTION_TEMPLATE_MATCHER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold on every clock edge outside reset.
`define MTM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When cond holds, conseq must hold in the next cycle.
`define MTM_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`else

`define MTM_ASSERT(label, prop, msg)
`define MTM_ASSERT_NEXT(label, cond, conseq, msg)

`endif

`endif

>>> hdl/mtm_pkg.sv
// Shared constants, types and stage words for the motion template matcher.
// No dependencies; imported by every module and interface of the block.
`timescale 1ns / 1ps
`default_nettype none

package mtm_pkg;

    localparam int SEQ_LEN     = 20;
    localparam int POS_W       = $clog2(SEQ_LEN);
    localparam int SAMPLE_W    = 6;
    localparam int ACCEL_W     = 16;
    localparam int DIFF_W      = ACCEL_W + 1;
    localparam int SQ_W        = 2 * DIFF_W - 1;
    localparam int LIMIT_W     = 16;
    localparam int LIMSQ_W     = 2 * LIMIT_W;
    localparam int DIST_W      = 34;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd448;

    localparam logic CMD_RECORD  = 1'b0;
    localparam logic CMD_COMPARE = 1'b1;

    typedef logic signed [ACCEL_W-1:0] accel_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic [POS_W-1:0]          pos_t;

    typedef struct packed {
        accel_t x;
        accel_t y;
        accel_t z;
    } vec_t;

    typedef struct packed {
        logic   command;
        logic   first_sample;
        vec_t   accel;
    } in_word_t;

    typedef struct packed {
        pos_t   idx;
        logic   last;
        logic   start;
        logic   compare;
        diff_t  diff_x;
        diff_t  diff_y;
        diff_t  diff_z;
    } diff_word_t;

    typedef struct packed {
        pos_t               idx;
        logic               last;
        logic               start;
        logic               compare;
        logic [SQ_W-1:0]    sq_x;
        logic [SQ_W-1:0]    sq_y;
        logic [SQ_W-1:0]    sq_z;
        logic [LIMSQ_W-1:0] lim_sq;
    } sq_word_t;

endpackage

`default_nettype wire

>>> hdl/mtm_in_if.sv
// Input sample channel: valid/ready handshake with one acceleration word.
// Depends on mtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mtm_in_if
    import mtm_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   command;
    logic   first_sample;
    accel_t accel_x;
    accel_t accel_y;
    accel_t accel_z;

    modport source (
        output valid, command, first_sample, accel_x, accel_y, accel_z,
        input  ready
    );

    modport sink (
        input  valid, command, first_sample, accel_x, accel_y, accel_z,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/mtm_out_if.sv
// Result channel: valid/ready handshake with one verdict word per sample.
// Depends on mtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mtm_out_if
    import mtm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_number;
    logic                sequence_done;
    logic [DIST_W-1:0]   distance_squared;
    logic                match;

    modport source (
        output valid, sample_number, sequence_done, distance_squared, match,
        input  ready
    );

    modport sink (
        input  valid, sample_number, sequence_done, distance_squared, match,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/mtm_filter_stage.sv
// Input register, smoothing filter, sequence position and template store.
// Depends on mtm_pkg, mtm_in_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "motion_template_matcher_unit_assert.svh"

module mtm_filter_stage
    import mtm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    mtm_in_if.sink          sample_in,
    output diff_word_t      a_word,
    output logic            a_valid,
    input  wire logic       a_ready
);

    logic       in_valid_reg, in_valid_next;
    in_word_t   in_word_reg;
    diff_word_t a_word_reg, a_word_next;
    logic       a_valid_reg, a_valid_next;
    vec_t       filt_reg, filt_next;
    pos_t       position_reg, position_next;
    logic       tvalid_reg, tvalid_next;
    vec_t       tmpl_reg [SEQ_LEN];

    logic       adv;
    logic       start;
    logic       last;
    logic       use_dist;
    pos_t       idx;
    vec_t       raw;
    vec_t       smooth;
    vec_t       tmpl_rd;
    diff_t      sum_x, sum_y, sum_z;

    assign adv             = in_valid_reg && (!a_valid_reg || a_ready);
    assign sample_in.ready = !in_valid_reg || adv;

    assign raw     = in_word_reg.accel;
    assign start   = in_word_reg.first_sample || (position_reg == '0);
    assign idx     = start ? '0 : position_reg;
    assign last    = (idx == POS_W'(SEQ_LEN - 1));
    assign tmpl_rd = tmpl_reg[idx];

    // Halve with floor: drop the low bit of the 17-bit sum.
    assign sum_x = DIFF_W'(raw.x) + DIFF_W'(filt_reg.x);
    assign sum_y = DIFF_W'(raw.y) + DIFF_W'(filt_reg.y);
    assign sum_z = DIFF_W'(raw.z) + DIFF_W'(filt_reg.z);

    always_comb
    begin
        smooth   = start ? raw : vec_t'{x: sum_x[DIFF_W-1:1], y: sum_y[DIFF_W-1:1],
                                        z: sum_z[DIFF_W-1:1]};
        use_dist = (in_word_reg.command == CMD_COMPARE) && tvalid_reg;

        a_word_next.idx     = idx;
        a_word_next.last    = last;
        a_word_next.start   = start;
        a_word_next.compare = (in_word_reg.command == CMD_COMPARE);
        a_word_next.diff_x  = use_dist ? DIFF_W'(tmpl_rd.x) - DIFF_W'(smooth.x) : '0;
        a_word_next.diff_y  = use_dist ? DIFF_W'(tmpl_rd.y) - DIFF_W'(smooth.y) : '0;
        a_word_next.diff_z  = use_dist ? DIFF_W'(tmpl_rd.z) - DIFF_W'(smooth.z) : '0;

        filt_next     = adv ? smooth : filt_reg;
        position_next = adv ? (last ? '0 : POS_W'(idx + 1'b1)) : position_reg;

        tvalid_next = tvalid_reg;
        if (adv && (in_word_reg.command == CMD_RECORD))
        begin
            if (idx == '0)
                tvalid_next = 1'b0;
            if (last)
                tvalid_next = 1'b1;
        end

        in_valid_next = sample_in.ready ? sample_in.valid : in_valid_reg;
        a_valid_next  = adv ? 1'b1 : (a_ready ? 1'b0 : a_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            a_valid_reg  <= 1'b0;
            filt_reg     <= '0;
            position_reg <= '0;
            tvalid_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            a_valid_reg  <= a_valid_next;
            filt_reg     <= filt_next;
            position_reg <= position_next;
            tvalid_reg   <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_in.valid && sample_in.ready)
        begin
            in_word_reg.command      <= sample_in.command;
            in_word_reg.first_sample <= sample_in.first_sample;
            in_word_reg.accel        <= '{x: sample_in.accel_x, y: sample_in.accel_y,
                                          z: sample_in.accel_z};
        end
        if (adv)
            a_word_reg <= a_word_next;
        if (adv && (in_word_reg.command == CMD_RECORD))
            tmpl_reg[idx] <= smooth;
    end

    assign a_word  = a_word_reg;
    assign a_valid = a_valid_reg;

    `MTM_ASSERT(a_pos_in_range, position_reg <= POS_W'(SEQ_LEN - 1),
        "sequence position left its range")
    `MTM_ASSERT_NEXT(a_tvalid_set, adv && last && (in_word_reg.command == CMD_RECORD),
        tvalid_reg, "template not marked valid after last record sample")
    `MTM_ASSERT_NEXT(a_pos_wrap, adv && last, position_reg == '0,
        "position did not wrap after last sample")

endmodule

`default_nettype wire

>>> hdl/mtm_square_stage.sv
// Squares the per-axis template differences and the distance limit.
// Depends on mtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtm_square_stage
    import mtm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire diff_word_t          a_word,
    input  wire logic                a_valid,
    output logic                     a_ready,
    input  wire logic [LIMIT_W-1:0]  distance_limit,
    output sq_word_t                 b_word,
    output logic                     b_valid,
    input  wire logic                b_ready
);

    sq_word_t b_word_reg, b_word_next;
    logic     b_valid_reg, b_valid_next;
    logic     adv;
    logic signed [2*DIFF_W-1:0] prod_x, prod_y, prod_z;

    assign a_ready = !b_valid_reg || b_ready;
    assign adv     = a_valid && a_ready;

    assign prod_x = a_word.diff_x * a_word.diff_x;
    assign prod_y = a_word.diff_y * a_word.diff_y;
    assign prod_z = a_word.diff_z * a_word.diff_z;

    always_comb
    begin
        b_word_next.idx     = a_word.idx;
        b_word_next.last    = a_word.last;
        b_word_next.start   = a_word.start;
        b_word_next.compare = a_word.compare;
        b_word_next.sq_x    = prod_x[SQ_W-1:0];
        b_word_next.sq_y    = prod_y[SQ_W-1:0];
        b_word_next.sq_z    = prod_z[SQ_W-1:0];
        b_word_next.lim_sq  = LIMSQ_W'(distance_limit) * LIMSQ_W'(distance_limit);
        b_valid_next        = adv ? 1'b1 : (b_ready ? 1'b0 : b_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= b_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            b_word_reg <= b_word_next;
    end

    assign b_word  = b_word_reg;
    assign b_valid = b_valid_reg;

endmodule

`default_nettype wire

>>> hdl/mtm_result_stage.sv
// Sums the squares, tracks the sticky mismatch and holds the result word.
// Depends on mtm_pkg, mtm_out_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "motion_template_matcher_unit_assert.svh"

module mtm_result_stage
    import mtm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire sq_word_t  b_word,
    input  wire logic      b_valid,
    output logic           b_ready,
    mtm_out_if.source      result_out
);

    logic                out_valid_reg, out_valid_next;
    logic                mismatch_reg, mismatch_next;
    logic [SAMPLE_W-1:0] number_reg;
    logic                done_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic                match_reg;
    logic                adv;
    logic [DIST_W-1:0]   dist_sum;
    logic                exceed;
    logic                mismatch_new;

    assign b_ready = !out_valid_reg || result_out.ready;
    assign adv     = b_valid && b_ready;

    assign dist_sum     = DIST_W'(b_word.sq_x) + DIST_W'(b_word.sq_y) + DIST_W'(b_word.sq_z);
    assign exceed       = dist_sum > DIST_W'(b_word.lim_sq);
    assign mismatch_new = (b_word.start ? 1'b0 : mismatch_reg) | exceed;

    always_comb
    begin
        mismatch_next  = adv ? mismatch_new : mismatch_reg;
        out_valid_next = adv ? 1'b1 : (result_out.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            mismatch_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            mismatch_reg  <= mismatch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            number_reg <= SAMPLE_W'(b_word.idx);
            done_reg   <= b_word.last;
            dist_reg   <= dist_sum;
            match_reg  <= b_word.last && b_word.compare && !mismatch_new;
        end
    end

    assign result_out.valid            = out_valid_reg;
    assign result_out.sample_number    = number_reg;
    assign result_out.sequence_done    = done_reg;
    assign result_out.distance_squared = dist_reg;
    assign result_out.match            = match_reg;

    `MTM_ASSERT(a_match_on_last, !(out_valid_reg && match_reg) || done_reg,
        "match reported on a sample that does not end its sequence")
    `MTM_ASSERT_NEXT(a_mismatch_sticky, adv && !b_word.start && mismatch_reg,
        mismatch_reg, "mismatch cleared inside a sequence")

endmodule

`default_nettype wire

>>> hdl/motion_template_matcher_unit.sv
// Top level of the motion template matcher: config register and stage chain.
// Depends on mtm_pkg, mtm_in_if, mtm_out_if and the three stage modules.
`timescale 1ns / 1ps
`default_nettype none

// Motion template matcher. Each accepted word is one 3-axis acceleration
// sample (signed Q8.8). Every axis is smoothed by a half-weight exponential
// filter that restarts on the first sample of a sequence. Record samples
// store the smoothed vector in a template of SEQ_LEN entries; compare
// samples produce the squared distance to the template entry at the same
// index and flag a mismatch when it exceeds distance_limit squared. The
// last sample of a compare sequence reports match = 1 if no sample of the
// sequence exceeded the limit, or if no full template has been recorded.
// Exactly one result word comes out per input word, in order. The block
// takes one word per cycle while the result channel does not stall it; a
// result word passes the input register, then smoothing and template read,
// squaring, and sum and compare into the output register. Every stage has
// its own valid bit, so empty stages keep filling while the output word
// waits for ready. Write distance_limit only while the block is idle; it
// resets to 448 (1.75).
module motion_template_matcher_unit
    import mtm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    mtm_in_if.sink                  sample_in,
    mtm_out_if.source               result_out,
    input  wire logic               distance_limit_we,
    input  wire logic [LIMIT_W-1:0] distance_limit_wdata
);

    logic [LIMIT_W-1:0] limit_reg, limit_next;

    diff_word_t a_word;
    logic       a_valid;
    logic       a_ready;
    sq_word_t   b_word;
    logic       b_valid;
    logic       b_ready;

    // Hold the limit until a write replaces it.
    assign limit_next = distance_limit_we ? distance_limit_wdata : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else
            limit_reg <= limit_next;
    end

    // Register the sample, smooth it, advance the position, read or write
    // the template.
    mtm_filter_stage u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_in),
        .a_word    (a_word),
        .a_valid   (a_valid),
        .a_ready   (a_ready)
    );

    // Square the differences and the limit.
    mtm_square_stage u_square (
        .clk            (clk),
        .rst_n          (rst_n),
        .a_word         (a_word),
        .a_valid        (a_valid),
        .a_ready        (a_ready),
        .distance_limit (limit_reg),
        .b_word         (b_word),
        .b_valid        (b_valid),
        .b_ready        (b_ready)
    );

    // Sum, compare, update the sticky mismatch and drive the result word.
    mtm_result_stage u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .b_word     (b_word),
        .b_valid    (b_valid),
        .b_ready    (b_ready),
        .result_out (result_out)
    );

endmodule

`default_nettype wire
